// ===== design/decimal_cycle_length_macros.svh =====
// Assertion macros shared by the decimal_cycle_length RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef DECIMAL_CYCLE_LENGTH_MACROS_SVH
`define DECIMAL_CYCLE_LENGTH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DCL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DCL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dcl_pkg.sv =====
// Package for decimal_cycle_length: widths, payload structs, back-end states
// and the modular helpers of the long-division step. No dependencies.
`timescale 1ns / 1ps

package dcl_pkg;

  localparam int NUM_BITS    = 32;
  localparam int DEN_BITS    = 12;
  localparam int STORE_DEPTH = 1 << DEN_BITS;
  localparam int QUEUE_DEPTH = 2;
  localparam int MOD_CNT_W   = $clog2(NUM_BITS);

  typedef struct packed {
    logic [NUM_BITS-1:0] numer;
    logic [DEN_BITS-1:0] denom;
  } in_t;

  typedef struct packed {
    logic [DEN_BITS-1:0] cycle_len;
    logic                terminates;
    logic                div_error;
  } out_t;

  typedef struct packed {
    logic [NUM_BITS-1:0] numer;
    logic [DEN_BITS-1:0] denom;
    logic                zero_den;
  } job_t;

  typedef struct packed {
    logic                seen;
    logic [DEN_BITS-1:0] idx;
  } store_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CLEAR,
    ST_PRIME,
    ST_WALK,
    ST_DONE
  } back_state_t;

  // 2*x mod d, for x < d
  function automatic logic [DEN_BITS-1:0] mod_dbl(input logic [DEN_BITS-1:0] x,
                                                  input logic [DEN_BITS-1:0] d);
    logic [DEN_BITS:0] y;
    y = {x, 1'b0};
    if (y >= {1'b0, d}) y = y - {1'b0, d};
    return y[DEN_BITS-1:0];
  endfunction

  // (a + b) mod d, for a, b < d
  function automatic logic [DEN_BITS-1:0] mod_add(input logic [DEN_BITS-1:0] a,
                                                  input logic [DEN_BITS-1:0] b,
                                                  input logic [DEN_BITS-1:0] d);
    logic [DEN_BITS:0] y;
    y = {1'b0, a} + {1'b0, b};
    if (y >= {1'b0, d}) y = y - {1'b0, d};
    return y[DEN_BITS-1:0];
  endfunction

  // 10*x mod d, for x < d
  function automatic logic [DEN_BITS-1:0] mod_ten(input logic [DEN_BITS-1:0] x,
                                                  input logic [DEN_BITS-1:0] d);
    logic [DEN_BITS-1:0] x2;
    logic [DEN_BITS-1:0] x4;
    logic [DEN_BITS-1:0] x5;
    x2 = mod_dbl(x, d);
    x4 = mod_dbl(x2, d);
    x5 = mod_add(x4, x, d);
    return mod_dbl(x5, d);
  endfunction

endpackage

// ===== design/dcl_front.sv =====
// Input stage of decimal_cycle_length: registers each transaction and flags
// a zero denominator. Depends on dcl_pkg.
`timescale 1ns / 1ps

module dcl_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dcl_pkg::in_t  in_data,
  output logic          push_valid,
  input  logic          push_ready,
  output dcl_pkg::job_t push_data
);
  import dcl_pkg::*;

  logic valid_r;
  job_t job_r;

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_data  = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job_r.numer    <= in_data.numer;
      job_r.denom    <= in_data.denom;
      job_r.zero_den <= (in_data.denom == '0);
    end
  end

endmodule

// ===== design/dcl_queue.sv =====
// Short FIFO of classified jobs between front and back of decimal_cycle_length.
// Depends on dcl_pkg.
`timescale 1ns / 1ps

module dcl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  dcl_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output dcl_pkg::job_t pop_data
);
  import dcl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/dcl_back.sv =====
// Execution side of decimal_cycle_length: serial remainder, store sweep, and
// the long-division walk over the seen-remainder memory. Depends on dcl_pkg.
`timescale 1ns / 1ps
`include "decimal_cycle_length_macros.svh"

module dcl_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  dcl_pkg::job_t q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dcl_pkg::out_t out_data
);
  import dcl_pkg::*;

  back_state_t          state_r;
  back_state_t          state_nxt;
  logic [NUM_BITS-1:0]  n_r;
  logic [DEN_BITS-1:0]  d_r;
  logic [DEN_BITS-1:0]  rem_r;
  logic [DEN_BITS-1:0]  rem_nxt;
  logic [DEN_BITS-1:0]  count_r;
  logic [MOD_CNT_W-1:0] mod_cnt_r;
  logic [DEN_BITS-1:0]  clr_addr_r;
  logic                 byp_r;
  logic [DEN_BITS-1:0]  byp_idx_r;
  store_entry_t         rd_r;
  out_t                 res_r;
  logic                 out_valid_r;
  out_t                 out_data_r;

  store_entry_t         mem [STORE_DEPTH];
  logic                 mem_we;
  logic [DEN_BITS-1:0]  mem_waddr;
  store_entry_t         mem_wdata;
  logic                 mem_re;
  logic [DEN_BITS-1:0]  mem_raddr;

  logic [DEN_BITS:0]    mod_trial;
  logic [DEN_BITS-1:0]  mod_step;
  logic                 seen;
  logic [DEN_BITS-1:0]  hit_idx;
  logic                 walk_stop;
  logic                 out_load;

  assign mod_trial = {rem_r, n_r[NUM_BITS-1]};
  assign mod_step  = (mod_trial >= {1'b0, d_r}) ? DEN_BITS'(mod_trial - {1'b0, d_r})
                                                : mod_trial[DEN_BITS-1:0];
  assign rem_nxt   = mod_ten(rem_r, d_r);
  assign seen      = byp_r || rd_r.seen;
  assign hit_idx   = byp_r ? byp_idx_r : rd_r.idx;
  assign walk_stop = (rem_r == '0) || seen;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) state_nxt = q_data.zero_den ? ST_DONE : ST_MOD;
      end
      ST_MOD: begin
        if (mod_cnt_r == MOD_CNT_W'(NUM_BITS - 1)) state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (clr_addr_r == '1) state_nxt = ST_PRIME;
      end
      ST_PRIME: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (walk_stop) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_ready   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = rem_r;
    case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_PRIME: begin
        mem_re = 1'b1;
      end
      ST_WALK: begin
        if (!walk_stop) begin
          mem_we         = 1'b1;
          mem_waddr      = rem_r;
          mem_wdata.seen = 1'b1;
          mem_wdata.idx  = count_r;
          mem_re         = 1'b1;
          mem_raddr      = rem_nxt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= res_r;
    case (state_r)
      ST_IDLE: begin
        n_r        <= q_data.numer;
        d_r        <= q_data.denom;
        rem_r      <= '0;
        mod_cnt_r  <= '0;
        clr_addr_r <= '0;
        res_r      <= '{cycle_len: '0, terminates: 1'b0, div_error: 1'b1};
      end
      ST_MOD: begin
        rem_r     <= mod_step;
        n_r       <= {n_r[NUM_BITS-2:0], 1'b0};
        mod_cnt_r <= mod_cnt_r + 1'b1;
      end
      ST_CLEAR: begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      ST_PRIME: begin
        count_r <= '0;
        byp_r   <= 1'b0;
      end
      ST_WALK: begin
        if (rem_r == '0) begin
          res_r <= '{cycle_len: '0, terminates: 1'b1, div_error: 1'b0};
        end else if (seen) begin
          res_r <= '{cycle_len: count_r - hit_idx, terminates: 1'b0, div_error: 1'b0};
        end else begin
          rem_r     <= rem_nxt;
          count_r   <= count_r + 1'b1;
          byp_r     <= (rem_nxt == rem_r);
          byp_idx_r <= count_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_r <= mem[mem_raddr];
  end

  `DCL_ASSERT_IMP(a_walk_rem_below_den, state_r == ST_WALK, rem_r < d_r, "remainder not below denominator")
  `DCL_ASSERT_IMP(a_walk_count_bound, state_r == ST_WALK, count_r < d_r, "digit count exceeds remainder space")
  `DCL_ASSERT_IMP(a_term_len_zero, out_valid_r && out_data_r.terminates, out_data_r.cycle_len == '0, "terminating result has nonzero length")
  `DCL_ASSERT_IMP(a_err_exclusive, out_valid_r && out_data_r.div_error, !out_data_r.terminates && out_data_r.cycle_len == '0, "error result carries data")
  `DCL_ASSERT_NXT(a_sweep_to_prime, state_r == ST_CLEAR && clr_addr_r == '1, state_r == ST_PRIME, "sweep did not end in prime")

endmodule

// ===== design/decimal_cycle_length.sv =====
// Top level of decimal_cycle_length: input stage, job queue and back end.
// Depends on dcl_pkg, dcl_front, dcl_queue and dcl_back.
//
// Usage:
//   in_valid/in_ready/in_data carry one fraction per transaction (numer, denom).
//   out_valid/out_ready/out_data return one result per transaction, in order:
//   cycle_len of the repeating decimal, terminates, and div_error for denom 0.
// Processing:
//   A zero denominator passes the input register, the queue and the back end's
//   done state to the output register. Otherwise the back end runs the serial
//   numer mod denom over the 32 numerator bits, sweeps the 4096-entry
//   seen-remainder memory, then walks one long-division digit per cycle (at most
//   denom - 1 digits) until it stops, and registers the result on out_data.
//   The back end takes a new item only once it is done with the last one;
//   the input stage and a two-entry queue keep accepting transactions meanwhile.
// Reset:
//   rst_n low clears all handshake state; queued items are dropped.
// Stall:
//   A held result sits in the output register; the back end finishes the next
//   item and waits, and the input side backs up once the queue is full.
`timescale 1ns / 1ps

module decimal_cycle_length (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dcl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dcl_pkg::out_t out_data
);
  import dcl_pkg::*;

  logic push_valid;
  logic push_ready;
  job_t push_data;
  logic pop_valid;
  logic pop_ready;
  job_t pop_data;

  dcl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  dcl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  dcl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_data    (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
